>>> design/command_driven_motor_pwm_controller_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor PWM controller
// Shared concurrent-assertion shorthands clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef COMMAND_DRIVEN_MOTOR_PWM_CONTROLLER_DEFINES_SVH
`define COMMAND_DRIVEN_MOTOR_PWM_CONTROLLER_DEFINES_SVH

// Same-cycle implication.
`define CDMPC_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define CDMPC_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

>>> design/cdmpc_pkg.sv
// ----------------------------------------------------------------------------
// cdmpc_pkg
// Command codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package cdmpc_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int REG_W = 8;

  localparam logic [7:0] CMD_FWD   = 8'h30;
  localparam logic [7:0] CMD_BACK  = 8'h31;
  localparam logic [7:0] CMD_TUR_L = 8'h34;
  localparam logic [7:0] CMD_TUR_R = 8'h35;
  localparam logic [7:0] CMD_FIRE  = 8'h36;
  localparam logic [7:0] CMD_UP    = 8'h37;
  localparam logic [7:0] CMD_DOWN  = 8'h38;

  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_PWM_PERIOD      = 2'd0;
  localparam reg_index_t REG_DRIVE_THRESHOLD = 2'd1;
  localparam reg_index_t REG_ELEVATION_MAX   = 2'd2;
  localparam reg_index_t REG_FIRE_PULSE_LEN  = 2'd3;

  localparam logic [REG_W-1:0] PWM_PERIOD_RST      = 8'd100;
  localparam logic [REG_W-1:0] DRIVE_THRESHOLD_RST = 8'd50;
  localparam logic [REG_W-1:0] ELEVATION_MAX_RST   = 8'd30;
  localparam logic [REG_W-1:0] FIRE_PULSE_LEN_RST  = 8'd30;

  typedef struct packed {
    logic [REG_W-1:0] pwm_period;
    logic [REG_W-1:0] drive_threshold;
    logic [REG_W-1:0] elevation_max;
    logic [REG_W-1:0] fire_pulse_len;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic elevation;
    logic drive;
  } pwm_levels_t;

endpackage

>>> design/cdmpc_cmd_if.sv
// ----------------------------------------------------------------------------
// cdmpc_cmd_if
// Input channel: a command byte or a timer tick per request.
// ----------------------------------------------------------------------------
interface cdmpc_cmd_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] cmd_byte;

  modport source (output valid, output kind, output cmd_byte, input ready);
  modport sink   (input valid, input kind, input cmd_byte, output ready);
endinterface

>>> design/cdmpc_res_if.sv
// ----------------------------------------------------------------------------
// cdmpc_res_if
// Result channel: bridge pins, PWM levels and the echoed byte.
// ----------------------------------------------------------------------------
interface cdmpc_res_if;
  logic       valid;
  logic       ready;
  logic       left_a;
  logic       left_b;
  logic       right_a;
  logic       right_b;
  logic       turret_a;
  logic       turret_b;
  logic       drive_pwm;
  logic       elevation_pwm;
  logic       fire_pwm;
  logic       echo_valid;
  logic [7:0] echo_byte;

  modport source (
    output valid, output left_a, output left_b, output right_a, output right_b,
    output turret_a, output turret_b, output drive_pwm, output elevation_pwm,
    output fire_pwm, output echo_valid, output echo_byte, input ready
  );
  modport sink (
    input valid, input left_a, input left_b, input right_a, input right_b,
    input turret_a, input turret_b, input drive_pwm, input elevation_pwm,
    input fire_pwm, input echo_valid, input echo_byte, output ready
  );
endinterface

>>> design/command_driven_motor_pwm_controller.sv
// ----------------------------------------------------------------------------
// command_driven_motor_pwm_controller
// Decodes command bytes into H-bridge pins and runs three tick-driven PWMs.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                         Accepted when
// cmd      in   kind, cmd_byte                                  valid && ready
// res      out  bridge pins, three PWM levels, echo_valid/byte  valid && ready
// wr       in   wr_index, wr_data                               wr_en
//
// The result of a request is registered on the edge that
// accepts it. The only stage is the result register, so a new request is taken
// every cycle while res is drained. A stall on res holds the result and drops
// cmd.ready. Reset is synchronous, clears all counters and the stored command,
// and loads the register defaults.
// ----------------------------------------------------------------------------
`include "command_driven_motor_pwm_controller_defines.svh"

module command_driven_motor_pwm_controller #(
  parameter int COUNT_WIDTH = cdmpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  cdmpc_cmd_if.sink             cmd,
  cdmpc_res_if.source           res,
  input  logic                  wr_en,
  input  cdmpc_pkg::reg_index_t wr_index,
  input  logic [7:0]            wr_data
);
  import cdmpc_pkg::*;

  cfg_t                   cfg;
  logic [7:0]             command;
  logic [COUNT_WIDTH-1:0] phase;
  logic [COUNT_WIDTH-1:0] elevation_duty;
  logic [COUNT_WIDTH-1:0] fire_duty;
  pwm_levels_t            levels;

  logic [COUNT_WIDTH-1:0] phase_next;
  logic [COUNT_WIDTH-1:0] elevation_duty_next;
  logic [COUNT_WIDTH-1:0] fire_duty_next;
  pwm_levels_t            levels_next;
  pwm_levels_t            levels_out;
  logic [7:0]             command_next;
  logic                   accept;

  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  cdmpc_tick #(.COUNT_WIDTH(COUNT_WIDTH)) u_tick (
    .cfg                 (cfg),
    .command             (command),
    .phase               (phase),
    .elevation_duty      (elevation_duty),
    .fire_duty           (fire_duty),
    .phase_next          (phase_next),
    .elevation_duty_next (elevation_duty_next),
    .fire_duty_next      (fire_duty_next),
    .levels              (levels_next)
  );

  always_comb begin
    command_next = cmd.kind ? command : cmd.cmd_byte;
    levels_out   = cmd.kind ? levels_next : levels;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_period      <= PWM_PERIOD_RST;
      cfg.drive_threshold <= DRIVE_THRESHOLD_RST;
      cfg.elevation_max   <= ELEVATION_MAX_RST;
      cfg.fire_pulse_len  <= FIRE_PULSE_LEN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PWM_PERIOD:      cfg.pwm_period      <= wr_data;
        REG_DRIVE_THRESHOLD: cfg.drive_threshold <= wr_data;
        REG_ELEVATION_MAX:   cfg.elevation_max   <= wr_data;
        REG_FIRE_PULSE_LEN:  cfg.fire_pulse_len  <= wr_data;
        default:             cfg.pwm_period      <= cfg.pwm_period;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command        <= '0;
      phase          <= '0;
      elevation_duty <= '0;
      fire_duty      <= '0;
      levels         <= '0;
    end else if (accept) begin
      command <= command_next;
      if (cmd.kind) begin
        phase          <= phase_next;
        elevation_duty <= elevation_duty_next;
        fire_duty      <= fire_duty_next;
        levels         <= levels_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.left_a        <= command_next == CMD_FWD;
      res.left_b        <= command_next == CMD_BACK;
      res.right_a       <= command_next == CMD_FWD;
      res.right_b       <= command_next == CMD_BACK;
      res.turret_a      <= command_next == CMD_TUR_L;
      res.turret_b      <= command_next == CMD_TUR_R;
      res.drive_pwm     <= levels_out.drive;
      res.elevation_pwm <= levels_out.elevation;
      res.fire_pwm      <= levels_out.fire;
      res.echo_valid    <= !cmd.kind;
      res.echo_byte     <= cmd.kind ? 8'd0 : cmd.cmd_byte;
    end
  end

  `CDMPC_ASSERT_NEXT(a_echo_on_command, accept && !cmd.kind,
    res.valid && res.echo_valid && res.echo_byte == $past(cmd.cmd_byte),
    "command request did not produce its echo")
  `CDMPC_ASSERT_NEXT(a_no_echo_on_tick, accept && cmd.kind,
    res.valid && !res.echo_valid && res.echo_byte == 8'd0,
    "tick request produced an echo")
  `CDMPC_ASSERT_NEXT(a_levels_hold_on_command, accept && !cmd.kind,
    levels == $past(levels) && phase == $past(phase),
    "command request disturbed the PWM state")
  `CDMPC_ASSERT_NOW(a_bridge_exclusive, res.valid,
    !(res.left_a && res.left_b) && !(res.turret_a && res.turret_b),
    "bridge driven both ways")

endmodule

>>> design/cdmpc_tick.sv
// ----------------------------------------------------------------------------
// cdmpc_tick
// Next phase, ramped elevation duty, fire duty and PWM levels for one tick.
// ----------------------------------------------------------------------------
module cdmpc_tick #(
  parameter int COUNT_WIDTH = cdmpc_pkg::COUNT_WIDTH_DEF
) (
  input  cdmpc_pkg::cfg_t          cfg,
  input  logic [7:0]               command,
  input  logic [COUNT_WIDTH-1:0]   phase,
  input  logic [COUNT_WIDTH-1:0]   elevation_duty,
  input  logic [COUNT_WIDTH-1:0]   fire_duty,
  output logic [COUNT_WIDTH-1:0]   phase_next,
  output logic [COUNT_WIDTH-1:0]   elevation_duty_next,
  output logic [COUNT_WIDTH-1:0]   fire_duty_next,
  output cdmpc_pkg::pwm_levels_t   levels
);
  import cdmpc_pkg::*;

  localparam int EXT_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [EXT_W-1:0] CNT_MAX_EXT = EXT_W'(CNT_MAX);

  // Clamp an 8-bit register value into the counter range.
  function automatic logic [COUNT_WIDTH-1:0] sat_reg(input logic [REG_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (ext > CNT_MAX_EXT) begin
      return CNT_MAX;
    end
    return ext[COUNT_WIDTH-1:0];
  endfunction

  logic [COUNT_WIDTH-1:0] phase_inc;
  logic [COUNT_WIDTH-1:0] fire_load;

  always_comb begin
    phase_inc = phase + COUNT_WIDTH'(1);
    if (EXT_W'(phase_inc) >= EXT_W'(cfg.pwm_period)) begin
      phase_next = '0;
    end else begin
      phase_next = phase_inc;
    end

    levels.drive     = EXT_W'(phase_next) <= EXT_W'(cfg.drive_threshold);
    levels.elevation = phase_next < elevation_duty;

    elevation_duty_next = elevation_duty;
    if (command == CMD_UP) begin
      if (EXT_W'(elevation_duty) >= EXT_W'(cfg.elevation_max)) begin
        elevation_duty_next = sat_reg(cfg.elevation_max);
      end else if (elevation_duty != CNT_MAX) begin
        elevation_duty_next = elevation_duty + COUNT_WIDTH'(1);
      end
    end else if (command == CMD_DOWN) begin
      if (elevation_duty != '0) begin
        elevation_duty_next = elevation_duty - COUNT_WIDTH'(1);
      end
    end

    // The fire command reloads first; the decay then applies to the reload.
    fire_load = (command == CMD_FIRE) ? sat_reg(cfg.fire_pulse_len) : fire_duty;
    levels.fire = phase_next < fire_load;
    fire_duty_next = levels.fire ? fire_load - COUNT_WIDTH'(1) : fire_load;
  end

endmodule
